### src/ibccg_pkg.sv
package ibccg_pkg;

  localparam int NCORES     = 8;
  localparam int NCNT       = 6;
  localparam int CW         = 64;
  localparam int CNT_W      = $clog2(NCORES + 1);
  localparam int BITS_W     = NCORES - 1;
  localparam int MASK_W     = NCORES;
  localparam int SEL_W      = $clog2(NCNT);
  localparam int STEP_W     = $clog2(CW);
  localparam int THR_W      = 10;
  localparam int DLY_W      = 16;
  localparam int MC_W       = 3;
  localparam int IDLE_W     = 7;
  localparam int OUTC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IDX_IDLE   = 2;
  localparam int IDX_IOWAIT = 3;

  localparam logic [THR_W-1:0]  LOW_RESET   = THR_W'(20);
  localparam logic [THR_W-1:0]  HIGH_RESET  = THR_W'(100);
  localparam logic [DLY_W-1:0]  DELAY_RESET = DLY_W'(30);
  localparam logic [MC_W-1:0]   MC_RESET    = MC_W'(1);
  localparam logic [THR_W-1:0]  LOW_ZERO    = THR_W'(1);
  localparam logic [THR_W-1:0]  HIGH_ZERO   = THR_W'(50);
  localparam logic [MC_W-1:0]   MC_ZERO     = MC_W'(1);
  localparam logic [IDLE_W-1:0] IDLE_MAX    = IDLE_W'(100);

  localparam logic [OUTC_W-1:0] EN_NONE   = 2'd0;
  localparam logic [OUTC_W-1:0] EN_DONE   = 2'd1;
  localparam logic [OUTC_W-1:0] EN_FAIL   = 2'd2;
  localparam logic [OUTC_W-1:0] DIS_NONE  = 2'd0;
  localparam logic [OUTC_W-1:0] DIS_COUNT = 2'd1;
  localparam logic [OUTC_W-1:0] DIS_DONE  = 2'd2;
  localparam logic [OUTC_W-1:0] DIS_FAIL  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW      = 2'd0,
    CFG_HIGH     = 2'd1,
    CFG_DELAY    = 2'd2,
    CFG_MIN_CORE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             load;
    logic             sum_step;
    logic             scale;
    logic             div_step;
    logic             dec_en;
    logic             dec_dis;
    logic             out_load;
    logic [SEL_W-1:0] sel;
  } ibccg_cmd_t;

  typedef struct packed {
    logic [IDLE_W-1:0] idle_percent;
    logic [OUTC_W-1:0] enable_outcome;
    logic [OUTC_W-1:0] disable_outcome;
    logic [CNT_W-1:0]  cores_online;
    logic [MASK_W-1:0] online_mask;
    logic [DLY_W-1:0]  delay_count;
  } ibccg_res_t;

endpackage

### src/ibccg_if.sv
interface ibccg_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      prime;
  logic [ibccg_pkg::CW-1:0]  user_time;
  logic [ibccg_pkg::CW-1:0]  system_time;
  logic [ibccg_pkg::CW-1:0]  idle_time;
  logic [ibccg_pkg::CW-1:0]  iowait_time;
  logic [ibccg_pkg::CW-1:0]  irq_time;
  logic [ibccg_pkg::CW-1:0]  softirq_time;

  modport source (output valid, prime, user_time, system_time, idle_time, iowait_time,
                  irq_time, softirq_time, input ready);
  modport sink (input valid, prime, user_time, system_time, idle_time, iowait_time,
                irq_time, softirq_time, output ready);
endinterface

interface ibccg_result_if;
  logic                          valid;
  logic                          ready;
  logic [ibccg_pkg::IDLE_W-1:0]  idle_percent;
  logic [ibccg_pkg::OUTC_W-1:0]  enable_outcome;
  logic [ibccg_pkg::OUTC_W-1:0]  disable_outcome;
  logic [ibccg_pkg::CNT_W-1:0]   cores_online;
  logic [ibccg_pkg::MASK_W-1:0]  online_mask;
  logic [ibccg_pkg::DLY_W-1:0]   delay_count;

  modport source (output valid, idle_percent, enable_outcome, disable_outcome, cores_online,
                  online_mask, delay_count, input ready);
  modport sink (input valid, idle_percent, enable_outcome, disable_outcome, cores_online,
                online_mask, delay_count, output ready);
endinterface

### src/idle_based_core_count_governor.sv
// channel   | dir | beat payload
// ----------+-----+-------------------------------------------------------------
// sample    | in  | prime, user/system/idle/iowait/irq/softirq_time (64b each)
// result    | out | idle_percent, enable/disable_outcome, cores_online,
//           |     | online_mask, delay_count
// cfg       | in  | cfg_we, cfg_index, cfg_data (no wait, no read-back)
//
// Prime beat: the result loads in S_OUT, entered from accept. Other beats
// first pass the 6-step delta accumulate and the 64-step restoring divider.
// One sample in work at a time; the next is taken once its result is loaded.
// A result holds in the output register until taken; the next sample may be
// accepted meanwhile. Synchronous reset: all cores online, baseline zero.
module idle_based_core_count_governor (
  input  logic                                clk,
  input  logic                                rst,
  ibccg_sample_if.sink                        sample,
  ibccg_result_if.source                      result,
  input  logic                                cfg_we,
  input  logic [ibccg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ibccg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ibccg_pkg::ibccg_cmd_t                               cmd;
  ibccg_pkg::ibccg_res_t                               res;
  logic [ibccg_pkg::NCNT-1:0][ibccg_pkg::CW-1:0]       snap;
  logic                                                in_ready;
  logic                                                out_valid;

  assign snap[0] = sample.user_time;
  assign snap[1] = sample.system_time;
  assign snap[2] = sample.idle_time;
  assign snap[3] = sample.iowait_time;
  assign snap[4] = sample.irq_time;
  assign snap[5] = sample.softirq_time;

  assign sample.ready = in_ready;
  assign result.valid = out_valid;
  assign result.idle_percent    = res.idle_percent;
  assign result.enable_outcome  = res.enable_outcome;
  assign result.disable_outcome = res.disable_outcome;
  assign result.cores_online    = res.cores_online;
  assign result.online_mask     = res.online_mask;
  assign result.delay_count     = res.delay_count;

  ibccg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_prime  (sample.prime),
    .out_ready (result.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ibccg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .prime     (sample.prime),
    .snap      (snap),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

endmodule

### src/ibccg_ctrl.sv
module ibccg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_prime,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output ibccg_pkg::ibccg_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SUM     = 7'b0000010,
    S_SCALE   = 7'b0000100,
    S_DIV     = 7'b0001000,
    S_DEC_EN  = 7'b0010000,
    S_DEC_DIS = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t                         state, state_next;
  logic [ibccg_pkg::STEP_W-1:0]   step, step_next;
  logic                           out_valid_next;

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = in_prime ? S_OUT : S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.sel      = step[ibccg_pkg::SEL_W-1:0];
        if (step == ibccg_pkg::STEP_W'(ibccg_pkg::NCNT - 1)) begin
          step_next  = '0;
          state_next = S_SCALE;
        end else begin
          step_next = step + ibccg_pkg::STEP_W'(1);
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == ibccg_pkg::STEP_W'(ibccg_pkg::CW - 1)) begin
          step_next  = '0;
          state_next = S_DEC_EN;
        end else begin
          step_next = step + ibccg_pkg::STEP_W'(1);
        end
      end
      S_DEC_EN: begin
        cmd.dec_en = 1'b1;
        state_next = S_DEC_DIS;
      end
      S_DEC_DIS: begin
        cmd.dec_dis = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample taken while another is in work");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC_EN) |-> $past(state == S_DIV, 1) && $past(state == S_DIV, 64))
    else $error("divider did not run its full length");

endmodule

### src/ibccg_dp.sv
module ibccg_dp (
  input  logic                                                clk,
  input  logic                                                rst,
  input  ibccg_pkg::ibccg_cmd_t                               cmd,
  input  logic                                                prime,
  input  logic [ibccg_pkg::NCNT-1:0][ibccg_pkg::CW-1:0]       snap,
  input  logic                                                cfg_we,
  input  logic [ibccg_pkg::CFG_IDX_W-1:0]                     cfg_index,
  input  logic [ibccg_pkg::CFG_DATA_W-1:0]                    cfg_data,
  output ibccg_pkg::ibccg_res_t                               res
);

  localparam int CW     = ibccg_pkg::CW;
  localparam int NCNT   = ibccg_pkg::NCNT;
  localparam int THR_W  = ibccg_pkg::THR_W;
  localparam int CNT_W  = ibccg_pkg::CNT_W;
  localparam int BITS_W = ibccg_pkg::BITS_W;
  localparam int DLY_W  = ibccg_pkg::DLY_W;
  localparam int IDLE_W = ibccg_pkg::IDLE_W;

  logic [THR_W-1:0]               low_thr, high_thr;
  logic [DLY_W-1:0]               delay_thr;
  logic [ibccg_pkg::MC_W-1:0]     min_core;

  logic [CW-1:0]                  prev [NCNT];
  logic [CW-1:0]                  delta [NCNT];
  logic [CW-1:0]                  acc, tsum, quo, rem;
  logic                           prime_r;

  logic [BITS_W-1:0]              online_bits;
  logic [CNT_W-1:0]               core_count;
  logic [DLY_W-1:0]               run;
  logic [ibccg_pkg::OUTC_W-1:0]   en_out, dis_out;
  logic [IDLE_W-1:0]              idle_sat;

  logic [CW:0]                    shifted;
  logic                           fits;
  logic                           big;
  logic [THR_W-1:0]               iq, lo_eff, hi_eff, lo_clamp;
  logic [ibccg_pkg::MC_W-1:0]     mc_eff;
  logic [THR_W+CNT_W:0]           prod_lo;
  logic [THR_W+CNT_W-1:0]         prod_hi;
  logic                           en_cond, dis_cond;
  logic                           en_found, dis_found;
  logic [BITS_W-1:0]              en_bits, dis_bits;
  logic [DLY_W:0]                 run_inc;

  always_comb begin
    shifted = {rem, quo[CW-1]};
    fits    = shifted >= {1'b0, acc};
    big     = |quo[CW-1:THR_W];
    iq      = quo[THR_W-1:0];
    hi_eff  = (high_thr == '0) ? ibccg_pkg::HIGH_ZERO : high_thr;
    lo_eff  = (low_thr == '0) ? ibccg_pkg::LOW_ZERO : low_thr;
    lo_clamp = (lo_eff > hi_eff) ? hi_eff : lo_eff;
    mc_eff  = (min_core == '0) ? ibccg_pkg::MC_ZERO : min_core;
    // idle < lo/c  <=>  (idle+1)*c <= lo ;  idle > hi/c  <=>  idle*c > hi
    prod_lo = ({1'b0, iq} + (THR_W+1)'(1)) * {1'b0, core_count};
    prod_hi = iq * core_count;
    en_cond  = !big && (prod_lo <= (THR_W+CNT_W+1)'(lo_clamp));
    dis_cond = big || (prod_hi > (THR_W+CNT_W)'(hi_eff));
    run_inc  = {1'b0, run} + (DLY_W+1)'(1);

    en_found = 1'b0;
    en_bits  = online_bits;
    for (int j = 0; j < BITS_W; j++) begin
      if (!en_found && !online_bits[j]) begin
        en_found   = 1'b1;
        en_bits[j] = 1'b1;
      end
    end

    dis_found = 1'b0;
    dis_bits  = online_bits;
    for (int j = 0; j < BITS_W; j++) begin
      if (!dis_found && online_bits[j] && (j + 1 >= int'(mc_eff))) begin
        dis_found   = 1'b1;
        dis_bits[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr   <= ibccg_pkg::LOW_RESET;
      high_thr  <= ibccg_pkg::HIGH_RESET;
      delay_thr <= ibccg_pkg::DELAY_RESET;
      min_core  <= ibccg_pkg::MC_RESET;
    end else if (cfg_we) begin
      unique case (ibccg_pkg::cfg_idx_t'(cfg_index))
        ibccg_pkg::CFG_LOW:      low_thr   <= cfg_data[THR_W-1:0];
        ibccg_pkg::CFG_HIGH:     high_thr  <= cfg_data[THR_W-1:0];
        ibccg_pkg::CFG_DELAY:    delay_thr <= cfg_data[DLY_W-1:0];
        ibccg_pkg::CFG_MIN_CORE: min_core  <= cfg_data[ibccg_pkg::MC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCNT; i++) prev[i] <= '0;
      online_bits <= '1;
      core_count  <= CNT_W'(ibccg_pkg::NCORES);
      run         <= '0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < NCNT; i++) prev[i] <= snap[i];
      end
      if (cmd.dec_en && en_cond) begin
        run <= '0;
        if (en_found) begin
          online_bits <= en_bits;
          core_count  <= core_count + CNT_W'(1);
        end
      end
      if (cmd.dec_dis) begin
        if (!dis_cond) begin
          run <= '0;
        end else if (run_inc > (DLY_W+1)'(delay_thr)) begin
          run <= '0;
          if (dis_found) begin
            online_bits <= dis_bits;
            core_count  <= core_count - CNT_W'(1);
          end
        end else begin
          run <= run_inc[DLY_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prime_r <= prime;
      acc     <= CW'(1);
      for (int i = 0; i < NCNT; i++) begin
        delta[i] <= (snap[i] >= prev[i]) ? snap[i] - prev[i] : '0;
      end
    end
    if (cmd.sum_step) begin
      acc  <= acc + delta[cmd.sel];
      tsum <= delta[ibccg_pkg::IDX_IDLE] + delta[ibccg_pkg::IDX_IOWAIT];
    end
    if (cmd.scale) begin
      quo <= (tsum << 6) + (tsum << 5) + (tsum << 2);
      rem <= '0;
    end
    // restoring divide; a zero divisor yields all ones
    if (cmd.div_step) begin
      rem <= fits ? CW'(shifted - {1'b0, acc}) : shifted[CW-1:0];
      quo <= {quo[CW-2:0], fits};
    end
    if (cmd.dec_en) begin
      idle_sat <= (big || iq > THR_W'(ibccg_pkg::IDLE_MAX)) ? ibccg_pkg::IDLE_MAX
                                                           : iq[IDLE_W-1:0];
      en_out   <= !en_cond ? ibccg_pkg::EN_NONE
                           : (en_found ? ibccg_pkg::EN_DONE : ibccg_pkg::EN_FAIL);
    end
    if (cmd.dec_dis) begin
      if (!dis_cond) begin
        dis_out <= ibccg_pkg::DIS_NONE;
      end else if (run_inc > (DLY_W+1)'(delay_thr)) begin
        dis_out <= dis_found ? ibccg_pkg::DIS_DONE : ibccg_pkg::DIS_FAIL;
      end else begin
        dis_out <= ibccg_pkg::DIS_COUNT;
      end
    end
    if (cmd.out_load) begin
      res.idle_percent    <= prime_r ? '0 : idle_sat;
      res.enable_outcome  <= prime_r ? ibccg_pkg::EN_NONE : en_out;
      res.disable_outcome <= prime_r ? ibccg_pkg::DIS_NONE : dis_out;
      res.cores_online    <= core_count;
      res.online_mask     <= {online_bits, 1'b1};
      res.delay_count     <= run;
    end
  end

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    core_count == CNT_W'($countones(online_bits) + 1))
    else $error("core count out of step with online mask");

  a_idle_saturated: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.out_load) |-> res.idle_percent <= ibccg_pkg::IDLE_MAX)
    else $error("idle percent above saturation");

endmodule
